// ===== rtl/c2e_pkg.sv =====
// ----------------------------------------------------------------------------
// c2e_pkg
// Shared widths, constants and the month table for the calendar to epoch
// seconds converter.
// ----------------------------------------------------------------------------
package c2e_pkg;

  // field widths
  localparam int YEAR_W  = 7;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int SOD_W   = 17;
  localparam int DOY_W   = 9;
  localparam int EPOCH_W = 33;
  localparam int ZONE_W  = 17;

  // internal widths
  localparam int HPROD_W = 17;  // hour * 3600
  localparam int MSUM_W  = 12;  // minute * 60 + second
  localparam int FY_W    = 7;   // full years since 1970, up to 99
  localparam int LD_W    = 5;   // leap days since 1970, up to 25
  localparam int YDAYS_W = 16;  // days of the full years
  localparam int DAYS_W  = 17;  // days since 1970
  localparam int EDAY_W  = 32;  // days since 1970 in seconds

  // time constants
  localparam logic [11:0]     SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]      SECS_PER_MIN  = 6'd60;
  localparam logic [16:0]     SECS_PER_DAY  = 17'd86400;
  localparam logic [8:0]      DAYS_PER_YEAR = 9'd365;
  localparam logic [YEAR_W-1:0] CENTURY_SPLIT = 7'd70;
  localparam logic [7:0]      EPOCH_YEAR    = 8'd70;
  localparam logic [7:0]      YEAR_BIAS     = 8'd100;
  localparam logic [5:0]      LEAP_BASE     = 6'd18;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [ZONE_W-1:0]  ZONE_RESET = 17'd28800;

  // days in the months before a zero-based month index
  function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] idx);
    logic [DOY_W-1:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/c2e_ifs.sv =====
// ----------------------------------------------------------------------------
// c2e channel interfaces
// Valid/ready channels for the calendar reading, the converted result and
// the zone offset write port.
// ----------------------------------------------------------------------------
interface c2e_in_if
  import c2e_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year_two_digit;
  logic [MONTH_W-1:0] month_number;
  logic [DAY_W-1:0]   day_of_month;
  logic [HOUR_W-1:0]  hour_of_day;
  logic [MIN_W-1:0]   minute_of_hour;
  logic [SEC_W-1:0]   second_of_minute;

  modport source (output valid, year_two_digit, month_number, day_of_month,
                  hour_of_day, minute_of_hour, second_of_minute, input ready);
  modport sink   (input valid, year_two_digit, month_number, day_of_month,
                  hour_of_day, minute_of_hour, second_of_minute, output ready);
endinterface

interface c2e_out_if
  import c2e_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [SOD_W-1:0]          seconds_of_day;
  logic [DOY_W-1:0]          day_index_of_year;
  logic signed [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, seconds_of_day, day_index_of_year, epoch_seconds,
                  input ready);
  modport sink   (input valid, seconds_of_day, day_index_of_year, epoch_seconds,
                  output ready);
endinterface

interface c2e_cfg_if
  import c2e_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ZONE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/calendar_to_epoch_seconds_top.sv =====
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds_top
// Converts a real-time-clock reading into seconds of day, day of year and
// epoch seconds less a zone offset.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   carries one calendar reading per item (two-digit year, month,
//           day, hour, minute, second); years below 70 are 20xx.
//   out_if  carries one result item per input item: seconds since midnight,
//           zero-based day of year and epoch seconds minus the zone offset.
//   cfg_if  writes the zone offset; always ready, write only while idle.
// A result passes through a five-stage pipeline (split terms, year/day sums,
// day total, day-to-second multiply, final add and offset subtract).
// Throughput is one item per cycle while out_if does not stall.
// Each stage holds its own valid bit and takes a new item whenever it is
// empty or its successor moves, so when out_if stalls the bubbles close up
// first and in_if.ready only drops once all five stages are full.
// Reset empties the pipeline and loads the zone offset with 28800.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds_top
  import c2e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  c2e_in_if.sink    in_if,
  c2e_out_if.source out_if,
  c2e_cfg_if.sink   cfg_if
);

  // zone offset register
  logic [ZONE_W-1:0] zone_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= ZONE_RESET;
    end else if (cfg_if.valid) begin
      zone_r <= cfg_if.data;
    end
  end

  // stage valid bits and per-stage advance
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  logic s1_en, s2_en, s3_en, s4_en, s5_en;

  assign s5_en = !s5_valid_r || out_if.ready;
  assign s4_en = !s4_valid_r || s5_en;
  assign s3_en = !s3_valid_r || s4_en;
  assign s2_en = !s2_valid_r || s3_en;
  assign s1_en = !s1_valid_r || s2_en;

  assign in_if.ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= in_if.valid;
      if (s2_en) s2_valid_r <= s1_valid_r;
      if (s3_en) s3_valid_r <= s2_valid_r;
      if (s4_en) s4_valid_r <= s3_valid_r;
      if (s5_en) s5_valid_r <= s4_valid_r;
    end
  end

  // stage 1: clamp month and day, split time terms, year terms
  logic [MONTH_W-1:0] mon_idx_nxt;
  logic [DAY_W-1:0]   day_m1_nxt;
  logic [7:0]         since1900_nxt;
  logic [7:0]         ld_q_nxt;
  logic [HPROD_W-1:0] s1_hprod_r;
  logic [MSUM_W-1:0]  s1_msum_r;
  logic [DOY_W-1:0]   s1_dbm_r;
  logic [DAY_W-1:0]   s1_day_m1_r;
  logic               s1_leap_adj_r;
  logic [FY_W-1:0]    s1_fy_r;
  logic [LD_W-1:0]    s1_ld_r;

  always_comb begin
    if (in_if.month_number == '0) begin
      mon_idx_nxt = '0;
    end else if (in_if.month_number > MONTH_DEC) begin
      mon_idx_nxt = MONTH_DEC - 4'd1;
    end else begin
      mon_idx_nxt = in_if.month_number - 4'd1;
    end
    day_m1_nxt    = (in_if.day_of_month == '0) ? '0 : in_if.day_of_month - 5'd1;
    since1900_nxt = (in_if.year_two_digit < CENTURY_SPLIT) ?
                    8'(in_if.year_two_digit) + YEAR_BIAS : 8'(in_if.year_two_digit);
    ld_q_nxt      = (since1900_nxt + 8'd3) >> 2;
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_hprod_r    <= HPROD_W'(in_if.hour_of_day) * HPROD_W'(SECS_PER_HOUR);
      s1_msum_r     <= MSUM_W'(in_if.minute_of_hour) * MSUM_W'(SECS_PER_MIN)
                       + MSUM_W'(in_if.second_of_minute);
      s1_dbm_r      <= days_before_month(mon_idx_nxt);
      s1_day_m1_r   <= day_m1_nxt;
      s1_leap_adj_r <= (in_if.year_two_digit[1:0] == 2'b00) && (mon_idx_nxt >= MONTH_FEB);
      s1_fy_r       <= FY_W'(since1900_nxt - EPOCH_YEAR);
      s1_ld_r       <= LD_W'(ld_q_nxt - 8'(LEAP_BASE));
    end
  end

  // stage 2: seconds of day, day of year, days of full years
  logic [SOD_W-1:0]   s2_sod_r;
  logic [DOY_W-1:0]   s2_doy_r;
  logic [YDAYS_W-1:0] s2_ydays_r;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_sod_r   <= SOD_W'(s1_hprod_r) + SOD_W'(s1_msum_r);
      s2_doy_r   <= s1_dbm_r + DOY_W'(s1_day_m1_r) + DOY_W'(s1_leap_adj_r);
      s2_ydays_r <= YDAYS_W'(s1_fy_r) * YDAYS_W'(DAYS_PER_YEAR) + YDAYS_W'(s1_ld_r);
    end
  end

  // stage 3: days since 1970
  logic [SOD_W-1:0]  s3_sod_r;
  logic [DOY_W-1:0]  s3_doy_r;
  logic [DAYS_W-1:0] s3_days_r;

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_sod_r  <= s2_sod_r;
      s3_doy_r  <= s2_doy_r;
      s3_days_r <= DAYS_W'(s2_ydays_r) + DAYS_W'(s2_doy_r);
    end
  end

  // stage 4: days to seconds
  logic [SOD_W-1:0]  s4_sod_r;
  logic [DOY_W-1:0]  s4_doy_r;
  logic [EDAY_W-1:0] s4_eday_r;

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_sod_r  <= s3_sod_r;
      s4_doy_r  <= s3_doy_r;
      s4_eday_r <= EDAY_W'(s3_days_r) * EDAY_W'(SECS_PER_DAY);
    end
  end

  // stage 5: add time of day, subtract zone offset, output register
  logic [SOD_W-1:0]   s5_sod_r;
  logic [DOY_W-1:0]   s5_doy_r;
  logic [EPOCH_W-1:0] s5_epoch_r;
  logic [EPOCH_W-1:0] epoch_nxt;

  assign epoch_nxt = EPOCH_W'(s4_eday_r) + EPOCH_W'(s4_sod_r) - EPOCH_W'(zone_r);

  always_ff @(posedge clk) begin
    if (s5_en) begin
      s5_sod_r   <= s4_sod_r;
      s5_doy_r   <= s4_doy_r;
      s5_epoch_r <= epoch_nxt;
    end
  end

  assign out_if.valid             = s5_valid_r;
  assign out_if.seconds_of_day    = s5_sod_r;
  assign out_if.day_index_of_year = s5_doy_r;
  assign out_if.epoch_seconds     = $signed(s5_epoch_r);

endmodule

// ===== rtl/c2e_checker.sv =====
// ----------------------------------------------------------------------------
// c2e_port_checks
// Port-level checks on the result channel of the calendar converter.
// ----------------------------------------------------------------------------
module c2e_port_checks
  import c2e_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [SOD_W-1:0]          out_seconds_of_day,
  input logic [DOY_W-1:0]          out_day_index_of_year,
  input logic signed [EPOCH_W-1:0] out_epoch_seconds
);

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seconds_of_day)
      && $stable(out_day_index_of_year) && $stable(out_epoch_seconds))
    else $error("stalled result changed");

  // day of year never passes the last day of a leap year
  a_doy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_day_index_of_year <= 9'd365)
    else $error("day of year out of range");

  // time of day stays within the largest sum of the time fields
  a_sod_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_seconds_of_day <= 17'd115443)
    else $error("seconds of day out of range");

endmodule

bind calendar_to_epoch_seconds_top c2e_port_checks u_c2e_port_checks (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_if.valid),
  .out_ready             (out_if.ready),
  .out_seconds_of_day    (out_if.seconds_of_day),
  .out_day_index_of_year (out_if.day_index_of_year),
  .out_epoch_seconds     (out_if.epoch_seconds)
);

// ===== bench/c2e_checker.sv =====
// ----------------------------------------------------------------------------
// c2e_checker
// Watches the reading, result and zone offset channels of the calendar to
// epoch seconds converter. Each accepted reading is converted here and the
// expected result is queued. Each accepted result is then compared with the
// oldest queued one, field by field.
// ----------------------------------------------------------------------------
module c2e_checker
  import c2e_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  c2e_in_if    in_if,
  c2e_out_if   out_if,
  c2e_cfg_if   cfg_if,
  output int   error_count,
  output int   queued
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DAY_SECS  = 86400;
  localparam int unsigned HOUR_SECS = 3600;
  localparam int unsigned MIN_SECS  = 60;
  localparam int unsigned YEAR_DAYS = 365;
  localparam int unsigned SPLIT_YR  = 70;

  // first day of each month in a common year
  localparam int unsigned MONTH_START [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct packed {
    logic [SOD_W-1:0]   seconds_of_day;
    logic [DOY_W-1:0]   day_index_of_year;
    logic [EPOCH_W-1:0] epoch_seconds;
  } conversion_t;

  conversion_t            pending_conversions [$];
  logic [ZONE_W-1:0]      zone_offset;
  int                     mismatches;

  // one reading to its three results under the given zone offset
  function automatic conversion_t convert_reading(
    input logic [YEAR_W-1:0]  yr,
    input logic [MONTH_W-1:0] mon,
    input logic [DAY_W-1:0]   day,
    input logic [HOUR_W-1:0]  hr,
    input logic [MIN_W-1:0]   mi,
    input logic [SEC_W-1:0]   se,
    input logic [ZONE_W-1:0]  zone
  );
    conversion_t res;
    int unsigned y, m, d, sod, doy, yrs_1900, days;
    logic [63:0] secs;
    y = yr;
    m = mon;
    d = day;
    sod = int'(hr) * HOUR_SECS + int'(mi) * MIN_SECS + int'(se);
    // out of range month and day clamp to the nearest valid one
    if (m == 0) m = 1;
    if (m > 12) m = 12;
    if (d == 0) d = 1;
    doy = MONTH_START[m - 1] + d - 1;
    if (yr[1:0] == 2'b00 && m > 2) doy = doy + 1;
    // years 0..69 belong to the next century
    yrs_1900 = (y < SPLIT_YR) ? y + 100 : y;
    days = (yrs_1900 - SPLIT_YR) * YEAR_DAYS + (yrs_1900 + 3) / 4 - 18 + doy;
    secs = 64'(days) * 64'(DAY_SECS) + 64'(sod) - 64'(zone);
    res.seconds_of_day    = sod[SOD_W-1:0];
    res.day_index_of_year = doy[DOY_W-1:0];
    res.epoch_seconds     = secs[EPOCH_W-1:0];
    return res;
  endfunction

  // track offset writes, queue predictions, compare results
  always @(posedge clk) begin : watch
    conversion_t want;
    if (!rst_n) begin
      zone_offset = ZONE_RESET;
      pending_conversions.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) zone_offset = cfg_if.data;
      if (out_if.valid && out_if.ready) begin
        if (pending_conversions.size() == 0) begin
          $error("result item with no reading outstanding");
          mismatches++;
        end else begin
          want = pending_conversions.pop_front();
          if (out_if.seconds_of_day !== want.seconds_of_day) begin
            $error("seconds_of_day: expected %0d, got %0d",
                   want.seconds_of_day, out_if.seconds_of_day);
            mismatches++;
          end
          if (out_if.day_index_of_year !== want.day_index_of_year) begin
            $error("day_index_of_year: expected %0d, got %0d",
                   want.day_index_of_year, out_if.day_index_of_year);
            mismatches++;
          end
          if (out_if.epoch_seconds !== want.epoch_seconds) begin
            $error("epoch_seconds: expected %0d, got %0d",
                   $signed(want.epoch_seconds), $signed(out_if.epoch_seconds));
            mismatches++;
          end
        end
      end
      if (in_if.valid && in_if.ready)
        pending_conversions.push_back(convert_reading(
          in_if.year_two_digit, in_if.month_number, in_if.day_of_month,
          in_if.hour_of_day, in_if.minute_of_hour, in_if.second_of_minute,
          zone_offset));
    end
    error_count <= mismatches;
    queued      <= pending_conversions.size();
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives calendar readings and zone offset writes into the converter, with
// random gaps on the reading side and random stalls on the result side, and
// gives the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb;
  import c2e_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 400;
  localparam int IDLE_PERCENT  = 23;

  logic clk;
  logic rst_n;
  logic calm;
  int   error_count;
  int   queued;
  int   quiet_cycles;

  c2e_in_if  in_ch ();
  c2e_out_if out_ch ();
  c2e_cfg_if cfg_ch ();

  calendar_to_epoch_seconds_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  c2e_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_if      (cfg_ch),
    .error_count (error_count),
    .queued      (queued)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side stalls at random except in the calm stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // give up once nothing has moved for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // one reading item, with random gaps ahead of it
  task automatic send_reading(
    input logic [YEAR_W-1:0]  yr,
    input logic [MONTH_W-1:0] mon,
    input logic [DAY_W-1:0]   day,
    input logic [HOUR_W-1:0]  hr,
    input logic [MIN_W-1:0]   mi,
    input logic [SEC_W-1:0]   se
  );
    logic took;
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.year_two_digit   <= yr;
    in_ch.month_number     <= mon;
    in_ch.day_of_month     <= day;
    in_ch.hour_of_day      <= hr;
    in_ch.minute_of_hour   <= mi;
    in_ch.second_of_minute <= se;
    // ready is settled by the falling edge
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // zone offset write, only with the pipeline empty
  task automatic write_zone(input logic [ZONE_W-1:0] offset);
    logic took;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= offset;
    do begin
      @(negedge clk);
      took = cfg_ch.ready;
      @(posedge clk);
    end while (!took);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop sending and wait for every result to come back
  task automatic drain;
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (queued != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [ZONE_W-1:0] zone;
    calm                   = 1'b0;
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.year_two_digit   = '0;
    in_ch.month_number     = '0;
    in_ch.day_of_month     = '0;
    in_ch.hour_of_day      = '0;
    in_ch.minute_of_hour   = '0;
    in_ch.second_of_minute = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.data            = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed readings under the reset offset
    send_reading(7'd70, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);      // epoch start, goes negative
    send_reading(7'd69, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59); // last second of 2069
    send_reading(7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_reading(7'd0, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0);     // leap day
    send_reading(7'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);       // after leap day
    send_reading(7'd1, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);       // common year
    send_reading(7'd72, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0);
    send_reading(7'd4, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);  // day index 365
    send_reading(7'd100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);     // year past 99
    send_reading(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);// every field at its top
    send_reading(7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);       // month and day zero
    send_reading(7'd50, 4'd13, 5'd15, 5'd6, 6'd30, 6'd30);  // month past December
    send_reading(7'd96, 4'd7, 5'd4, 5'd8, 6'd0, 6'd0);
    send_reading(7'd68, 4'd6, 5'd15, 5'd24, 6'd0, 6'd0);    // hour out of range
    send_reading(7'd85, 4'd11, 5'd30, 5'd0, 6'd60, 6'd61);  // minute, second out of range
    send_reading(7'd38, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7);
    send_reading(7'd127, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    drain;

    // random readings, one offset per phase
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       zone = '0;
        1:       zone = 17'd86399;
        2:       zone = '1;
        3:       zone = ZONE_W'($urandom_range(86399));
        default: zone = ZONE_RESET;
      endcase
      write_zone(zone);
      calm = (phase == 2);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) begin
          send_reading(YEAR_W'($urandom_range(99)), MONTH_W'($urandom_range(12, 1)),
                       DAY_W'($urandom_range(31, 1)), HOUR_W'($urandom_range(23)),
                       MIN_W'($urandom_range(59)), SEC_W'($urandom_range(59)));
        end else begin
          send_reading(YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
                       HOUR_W'($urandom), MIN_W'($urandom), SEC_W'($urandom));
        end
      end
      drain;
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
